[hw/rtl/ffa_pkg.sv]
package ffa_pkg;

  // largest per-packet flag-bit count; larger counts are clamped to it
  localparam logic [3:0] MAX_FLAG_BITS = 4'd8;

  // reset value of the emit threshold
  localparam logic [7:0] PPF_RESET = 8'd8;

  // saturation value of the per-slot packet count
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // one packet item
  typedef struct packed {
    logic [9:0]  flow_slot;
    logic [15:0] packet_length;
    logic [63:0] arrival_time;
    logic [3:0]  flag_bit_count;
  } pkt_t;

  // one completed-flow item
  typedef struct packed {
    logic [9:0]  done_slot;
    logic [15:0] length_min;
    logic [15:0] length_max;
    logic [23:0] length_sum;
    logic [63:0] gap_min;
    logic [63:0] gap_max;
    logic [63:0] gap_sum;
    logic [63:0] flow_duration;
    logic [10:0] flag_bit_sum;
  } feat_t;

  // one flow table entry
  typedef struct packed {
    logic [7:0]  count;
    logic [63:0] first_time;
    logic [63:0] last_time;
    logic [15:0] len_min;
    logic [15:0] len_max;
    logic [23:0] len_sum;
    logic [63:0] gap_min;
    logic [63:0] gap_max;
    logic [63:0] gap_sum;
    logic [10:0] flag_sum;
  } entry_t;

endpackage

[hw/rtl/flow_feature_accumulator_core.sv]
// Per-flow packet statistics. Each packet item names a flow slot; the slot's
// entry (count, first/last time, length min/max/sum, gap min/max/sum, flag
// sum) lives in one synchronous table of FLOW_SLOTS words with a registered
// read. A packet item is read from the table in the cycle it is accepted and
// updated and written back in the next cycle, with the just-written entry
// forwarded to a following packet on the same slot, so the block takes one
// packet per cycle unless the input is held off. When a slot's count reaches
// the ppf threshold its features are formed in the update stage and land in
// the result register; the input is held off in the cycle a result is being
// formed and while the result register holds an item that is not taken in
// that cycle. Packets whose slot is not below FLOW_SLOTS are accepted and
// dropped. After reset a pass over all slots clears the table counts, while no
// packet is accepted; cfg writes are taken at any time the block is idle.
module flow_feature_accumulator_core #(
  parameter int FLOW_SLOTS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  // packet items
  input  logic           pkt_valid,
  output logic           pkt_ready,
  input  ffa_pkg::pkt_t  pkt,
  // completed-flow items
  output logic           feat_valid,
  input  logic           feat_ready,
  output ffa_pkg::feat_t feat,
  // threshold register
  input  logic           cfg_wen,
  input  logic [7:0]     cfg_wdata
);

  localparam int IDX_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_SLOTS - 1);

  ffa_pkg::entry_t mem [FLOW_SLOTS];

  logic [7:0]       ppf;
  logic             clr_active;
  logic [IDX_W-1:0] clr_idx;

  logic             pkt_accept;
  logic             in_range;
  logic [IDX_W-1:0] rd_idx;
  ffa_pkg::entry_t  rd_data;

  logic             s1_valid;
  ffa_pkg::pkt_t    s1_pkt;
  logic [IDX_W-1:0] s1_idx;

  logic             wb_valid;
  logic [IDX_W-1:0] wb_idx;
  ffa_pkg::entry_t  wb_data;

  ffa_pkg::entry_t  entry_next;
  ffa_pkg::feat_t   feat_next;
  logic             s1_emit;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      ppf <= ffa_pkg::PPF_RESET;
    end else if (cfg_wen) begin
      ppf <= cfg_wdata;
    end
  end

  // clearing pass over the table after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      if (clr_idx == LAST_IDX) begin
        clr_active <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // input handshake: the result register must be free when this item finishes
  assign pkt_ready  = !clr_active && (!feat_valid || feat_ready) && !(s1_valid && s1_emit);
  assign pkt_accept = pkt_valid && pkt_ready;
  assign in_range   = 32'(pkt.flow_slot) < 32'(FLOW_SLOTS);
  assign rd_idx     = IDX_W'(pkt.flow_slot);

  // table write port: clearing pass or update write-back
  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_idx] <= '0;
    end else if (s1_valid) begin
      mem[s1_idx] <= entry_next;
    end
  end

  // table read port
  always_ff @(posedge clk) begin
    if (pkt_accept) begin
      rd_data <= mem[rd_idx];
    end
  end

  // update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pkt_accept && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_accept) begin
      s1_pkt <= pkt;
      s1_idx <= rd_idx;
    end
  end

  // last write-back, forwarded to a following item on the same slot
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      wb_idx  <= s1_idx;
      wb_data <= entry_next;
    end
  end

  // read-modify of the slot entry
  always_comb begin
    ffa_pkg::entry_t cur;
    logic [3:0]      flags;
    logic [63:0]     gap;
    logic [7:0]      cnt;

    cur   = (wb_valid && (wb_idx == s1_idx)) ? wb_data : rd_data;
    flags = (s1_pkt.flag_bit_count > ffa_pkg::MAX_FLAG_BITS) ?
            ffa_pkg::MAX_FLAG_BITS : s1_pkt.flag_bit_count;
    gap   = s1_pkt.arrival_time - cur.last_time;
    cnt   = (cur.count == ffa_pkg::COUNT_MAX) ? ffa_pkg::COUNT_MAX : cur.count + 8'd1;

    entry_next = cur;
    if (cur.count == 8'd0) begin
      // first packet of the flow
      entry_next.first_time = s1_pkt.arrival_time;
      entry_next.len_min    = s1_pkt.packet_length;
      entry_next.len_max    = s1_pkt.packet_length;
      entry_next.len_sum    = 24'(s1_pkt.packet_length);
      entry_next.gap_min    = '1;
      entry_next.gap_max    = '0;
      entry_next.gap_sum    = '0;
      entry_next.flag_sum   = 11'(flags);
    end else begin
      if (s1_pkt.packet_length < cur.len_min) begin
        entry_next.len_min = s1_pkt.packet_length;
      end
      if (s1_pkt.packet_length > cur.len_max) begin
        entry_next.len_max = s1_pkt.packet_length;
      end
      entry_next.len_sum = cur.len_sum + 24'(s1_pkt.packet_length);
      if (gap < cur.gap_min) begin
        entry_next.gap_min = gap;
      end
      if (gap > cur.gap_max) begin
        entry_next.gap_max = gap;
      end
      entry_next.gap_sum  = cur.gap_sum + gap;
      entry_next.flag_sum = cur.flag_sum + 11'(flags);
    end
    entry_next.last_time = s1_pkt.arrival_time;

    // threshold check; a completed flow restarts at count zero
    s1_emit = cnt >= ppf;
    entry_next.count = s1_emit ? 8'd0 : cnt;

    feat_next.done_slot     = s1_pkt.flow_slot;
    feat_next.length_min    = entry_next.len_min;
    feat_next.length_max    = entry_next.len_max;
    feat_next.length_sum    = entry_next.len_sum;
    feat_next.gap_min       = entry_next.gap_min;
    feat_next.gap_max       = entry_next.gap_max;
    feat_next.gap_sum       = entry_next.gap_sum;
    feat_next.flow_duration = s1_pkt.arrival_time - entry_next.first_time;
    feat_next.flag_bit_sum  = entry_next.flag_sum;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      feat_valid <= 1'b0;
    end else if (s1_valid && s1_emit) begin
      feat_valid <= 1'b1;
    end else if (feat_ready) begin
      feat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_emit) begin
      feat <= feat_next;
    end
  end

  // a completing item always finds the result register free
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit) |-> (!feat_valid || feat_ready))
    else $error("result register overwritten");

  // no item is taken while the table is being cleared
  assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !pkt_accept)
    else $error("item accepted during clearing pass");

  // a new result always comes from an item in the update stage
  assert property (@(posedge clk) disable iff (rst)
    $rose(feat_valid) |-> $past(s1_valid && s1_emit))
    else $error("result without a completing item");

  // nothing is emitted before the clearing pass ends
  assert property (@(posedge clk) disable iff (rst)
    clr_active |-> (!feat_valid && !s1_valid))
    else $error("activity during clearing pass");

endmodule
